[hdl/sva_pkg.sv]
// ----------------------------------------------------------------------------
// sva_pkg
// shared types and constants of the sound voice allocator
// ----------------------------------------------------------------------------
package sva_pkg;

	localparam int unsigned VOICES_DEF = 8;
	localparam int unsigned IDX_W      = 6;   // voice index width, covers up to 64 voices

	localparam int unsigned S_DATA_W = 88;
	localparam int unsigned M_DATA_W = 16;

	localparam logic signed [31:0] LIFE_INIT = 32'sh7fffffff;
	localparam logic [3:0]         SUB_ANY   = 4'hF;
	localparam logic [3:0]         SUB_NONE  = 4'h0;

	typedef enum logic [1:0] {
		OP_START = 2'd0,
		OP_STOP  = 2'd1,
		OP_CLEAR = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		ST_STARTED   = 3'd0,
		ST_SILENT    = 3'd1,
		ST_NO_VOICE  = 3'd2,
		ST_STOPPED   = 3'd3,
		ST_NOT_FOUND = 3'd4,
		ST_CLEARED   = 3'd5
	} status_t;

	// request walking down the row of voice cells
	typedef struct packed {
		logic               vld;
		logic [1:0]         op;
		logic [15:0]        ent;
		logic [3:0]         sub;
		logic [8:0]         snd;
		logic [23:0]        len;
		logic [30:0]        now;
		logic               aud;
		logic               done;   // exact match seen, later cells pass through
		logic               found;
		logic [IDX_W-1:0]   pick;
		logic signed [31:0] life;
		logic               stole;
	} token_t;

	// table update broadcast to all cells when a request leaves the row
	typedef struct packed {
		logic             en;
		logic [1:0]       op;
		logic [IDX_W-1:0] idx;
		logic [15:0]      ent;
		logic [3:0]       sub;
		logic [8:0]       snd;
		logic [31:0]      end_time;
		logic             aud;
	} commit_t;

endpackage

[hdl/sound_voice_allocator_core.sv]
// ----------------------------------------------------------------------------
// sound_voice_allocator_core
// voice table with allocation, stealing, stop and clear
// ----------------------------------------------------------------------------
// Each request walks a row of VOICES cells, one cell per clock; every cell
// owns one voice and folds its entry into the search (exact entity and
// sub-channel match, else the voice closest to its end time, never an active
// voice of the player entity for another requester). When the request leaves
// the last cell, the chosen cell is updated and the result is registered.
// One request is in the row at a time: it passes through the register of
// every cell in turn, and the last cell feeds the result register directly.
// The row is free again from the clock edge that registers the result, so a
// new request enters only after the previous one has left the row. The next
// input is taken while a result still waits on the output side, but not
// while a second result is held behind it. The user must write the player
// entity register through cfg_we/cfg_wdata only while no request is in
// flight; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module sound_voice_allocator_core #(
	parameter int unsigned VOICES = sva_pkg::VOICES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// operation[1:0], entity[17:2], sub_channel[21:18], sound_id[30:22],
	// sound_length[54:31], current_time[85:55], audible[86], zero fill
	input  logic [sva_pkg::S_DATA_W-1:0]  s_axis_tdata,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// voice_index[5:0], status[8:6], stole_active[9], zero fill
	output logic [sva_pkg::M_DATA_W-1:0]  m_axis_tdata,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// player entity register
	input  logic                          cfg_we,
	input  logic [15:0]                   cfg_wdata
);
	import sva_pkg::*;

	token_t      tok [VOICES+1];   // tok[0] enters cell 0, tok[VOICES] leaves the row
	logic        [VOICES-1:0] row_vld;
	commit_t     commit;
	logic [15:0] player_q;
	logic        busy_q;
	logic        s_xfer;
	logic        m_xfer;
	logic        res_vld;
	logic [M_DATA_W-1:0] res_data;
	logic [M_DATA_W-1:0] out_q;
	logic        out_vld_q;
	logic [M_DATA_W-1:0] pend_q;
	logic        pend_vld_q;
	logic        out_free;
	status_t     res_status;
	logic [IDX_W-1:0] res_idx;
	logic        res_stole;
	token_t      fin;

	assign s_axis_tready = !busy_q && !pend_vld_q;
	assign s_xfer        = s_axis_tvalid && s_axis_tready;
	assign m_xfer        = out_vld_q && m_axis_tready;

	// request token entering the first cell
	always_comb begin
		tok[0]       = '0;
		tok[0].vld   = s_xfer;
		tok[0].op    = s_axis_tdata[1:0];
		tok[0].ent   = s_axis_tdata[17:2];
		tok[0].sub   = s_axis_tdata[21:18];
		tok[0].snd   = s_axis_tdata[30:22];
		tok[0].len   = s_axis_tdata[54:31];
		tok[0].now   = s_axis_tdata[85:55];
		tok[0].aud   = s_axis_tdata[86];
		tok[0].life  = LIFE_INIT;
	end

	// row of voice cells
	for (genvar i = 0; i < VOICES; i++) begin : g_cell
		sva_cell #(
			.CELL_IDX (i)
		) u_cell (
			.clk           (clk),
			.arst_n        (arst_n),
			.player_entity (player_q),
			.tok_in        (tok[i]),
			.commit        (commit),
			.tok_out       (tok[i+1])
		);
		assign row_vld[i] = tok[i+1].vld;
	end

	assign fin = tok[VOICES];

	// table update and result as the request leaves the row
	always_comb begin
		commit          = '0;
		commit.op       = fin.op;
		commit.idx      = fin.pick;
		commit.ent      = fin.ent;
		commit.sub      = fin.sub;
		commit.snd      = fin.snd;
		commit.aud      = fin.aud;
		commit.end_time = {1'b0, fin.now} + {8'd0, fin.len};
		res_vld         = 1'b0;
		res_status      = ST_CLEARED;
		res_idx         = '0;
		res_stole       = 1'b0;
		if (fin.vld) begin
			case (fin.op)
				OP_START: begin
					res_vld   = 1'b1;
					commit.en = fin.found;
					if (fin.found) begin
						res_idx    = fin.pick;
						res_stole  = fin.stole;
						res_status = fin.aud ? ST_STARTED : ST_SILENT;
					end else begin
						res_status = ST_NO_VOICE;
					end
				end
				OP_STOP: begin
					res_vld   = 1'b1;
					commit.en = fin.found;
					if (fin.found) begin
						res_idx    = fin.pick;
						res_status = ST_STOPPED;
					end else begin
						res_status = ST_NOT_FOUND;
					end
				end
				OP_CLEAR: begin
					res_vld    = 1'b1;
					commit.en  = 1'b1;
					res_status = ST_CLEARED;
				end
				default: ;   // unused code: no result, no table change
			endcase
		end
		res_data = {(M_DATA_W-10)'(0), res_stole, res_status, res_idx};
	end

	// player entity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			player_q <= '0;
		end else if (cfg_we) begin
			player_q <= cfg_wdata;
		end
	end

	// one request in flight: busy from input transfer until it leaves the row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (s_xfer) begin
			busy_q <= 1'b1;
		end else if (fin.vld) begin
			busy_q <= 1'b0;
		end
	end

	// output register plus one holding slot for a result that finds it full
	assign out_free = !out_vld_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			pend_vld_q <= 1'b0;
		end else begin
			if (pend_vld_q) begin
				if (out_free) begin
					out_vld_q  <= 1'b1;
					pend_vld_q <= 1'b0;
				end
			end else if (res_vld) begin
				if (out_free) begin
					out_vld_q <= 1'b1;
				end else begin
					pend_vld_q <= 1'b1;
				end
			end else if (m_xfer) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pend_vld_q) begin
			if (out_free) begin
				out_q <= pend_q;
			end
		end else if (res_vld) begin
			if (out_free) begin
				out_q <= res_data;
			end else begin
				pend_q <= res_data;
			end
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_q;

	// at most one request in the row
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(row_vld))
		else $error("more than one request in the cell row");

	// a request in the row keeps the input closed
	a_busy_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(row_vld != '0) |-> (busy_q && !s_axis_tready))
		else $error("input open while a request is in the row");

	// holding slot is only used behind a full output register
	a_pend_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		pend_vld_q |-> out_vld_q)
		else $error("held result without a result on the output");

	// no request leaves the row while a result is still held
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		pend_vld_q |-> !fin.vld)
		else $error("result would overrun the holding slot");

	// an accepted request enters the first cell on the next cycle
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_xfer |=> row_vld[0])
		else $error("request did not enter the first cell");

endmodule

[hdl/sva_cell.sv]
// ----------------------------------------------------------------------------
// sva_cell
// one voice of the table with its slice of the allocation search
// ----------------------------------------------------------------------------
module sva_cell #(
	parameter int unsigned CELL_IDX = 0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [15:0]      player_entity,
	input  sva_pkg::token_t  tok_in,
	input  sva_pkg::commit_t commit,
	output sva_pkg::token_t  tok_out
);
	import sva_pkg::*;

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

	logic               active_q;
	logic [15:0]        ent_q;
	logic [3:0]         sub_q;
	logic [8:0]         snd_q;
	logic [31:0]        end_q;
	token_t             tok_q;
	token_t             tok_d;
	logic               exact;
	logic               skip;
	logic               stop_hit;
	logic signed [31:0] left;

	always_comb begin
		tok_d = tok_in;
		exact = (tok_in.sub != SUB_NONE) && (ent_q == tok_in.ent) &&
			((sub_q == tok_in.sub) || (tok_in.sub == SUB_ANY));
		skip = (ent_q == player_entity) && (tok_in.ent != player_entity) && active_q;
		stop_hit = (ent_q == tok_in.ent) && (sub_q == tok_in.sub);
		left = $signed(end_q - {1'b0, tok_in.now});
		if (tok_in.vld && !tok_in.done) begin
			case (tok_in.op)
				OP_START: begin
					if (exact) begin
						tok_d.done  = 1'b1;
						tok_d.found = 1'b1;
						tok_d.pick  = MY_IDX;
						tok_d.stole = active_q;
					end else if (!skip && (left < tok_in.life)) begin
						tok_d.found = 1'b1;
						tok_d.life  = left;
						tok_d.pick  = MY_IDX;
						tok_d.stole = active_q;
					end
				end
				OP_STOP: begin
					if (stop_hit) begin
						tok_d.done  = 1'b1;
						tok_d.found = 1'b1;
						tok_d.pick  = MY_IDX;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_d;
		end
	end

	assign tok_out = tok_q;

	// voice table entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			ent_q    <= '0;
			sub_q    <= '0;
			snd_q    <= '0;
			end_q    <= '0;
		end else if (commit.en) begin
			case (commit.op)
				OP_CLEAR: begin
					active_q <= 1'b0;
					ent_q    <= '0;
					sub_q    <= '0;
					snd_q    <= '0;
					end_q    <= '0;
				end
				OP_STOP: begin
					if (commit.idx == MY_IDX) begin
						active_q <= 1'b0;
						end_q    <= '0;
					end
				end
				OP_START: begin
					if (commit.idx == MY_IDX) begin
						active_q <= commit.aud;
						ent_q    <= commit.ent;
						sub_q    <= commit.sub;
						snd_q    <= commit.aud ? commit.snd : '0;
						end_q    <= commit.aud ? commit.end_time : '0;
					end
				end
				default: ;
			endcase
		end
	end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the sound voice allocator core
// ----------------------------------------------------------------------------
// A voice table model runs beside the core. Every request transfer on the
// input stream is fed to the model, which queues any expected result. Every
// result transfer is compared field by field against the oldest queued one.
// A directed sequence covers the table corner cases first: a full table of
// protected player voices, voices whose remaining life is the life limit,
// wildcard and exact sub-channel hits, stops on inactive voices, silent
// claims and the unused opcode. Random phases follow, each writing a player
// entity and using one of four patterns of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_top;
	import sva_pkg::*;

	localparam int VOICES         = VOICES_DEF;
	localparam logic [1:0] OP_UNUSED = 2'd3;   // opcode the core drops
	localparam int PHASES         = 8;
	localparam int PHASE_ITEMS    = 106;
	localparam int SETTLE_CYCLES  = 2 * (VOICES + 1);
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int REPORT_LIMIT   = 10;

	localparam logic [15:0] ENTITY_POOL [4] = '{16'h0000, 16'h0007, 16'h8000, 16'hFFFF};
	localparam logic [15:0] PLAYER_SETTINGS [PHASES] = '{
		16'h0000, 16'hFFFF, 16'h0007, 16'h8000, 16'h1234, 16'h0000, 16'h0007, 16'h0000
	};

	typedef struct {
		logic [1:0]  op;
		logic [15:0] ent;
		logic [3:0]  sub;
		logic [8:0]  snd;
		logic [23:0] len;
		logic [30:0] now;
		logic        aud;
	} voice_req_t;

	typedef struct {
		logic [5:0] idx;
		status_t    status;
		logic       stole;
	} voice_result_t;

	// voice table model and queue of results still owed by the core
	class voice_scoreboard;
		logic [15:0]   player;
		logic          v_active [VOICES];
		logic [15:0]   v_entity [VOICES];
		logic [3:0]    v_sub    [VOICES];
		logic [8:0]    v_sound  [VOICES];
		logic [31:0]   v_end    [VOICES];
		voice_result_t pending [$];
		int mismatches, n_requests, n_checked;
		int n_started, n_silent, n_no_voice, n_stole, n_stopped, n_not_found, n_cleared;

		function void wipe();
			int i;
			for (i = 0; i < VOICES; i++) begin
				v_active[i] = 1'b0;
				v_entity[i] = '0;
				v_sub[i]    = '0;
				v_sound[i]  = '0;
				v_end[i]    = '0;
			end
		endfunction

		function void note_request(voice_req_t r);
			int i, pick;
			logic signed [31:0] best, left;
			voice_result_t res;
			res.idx    = '0;
			res.status = ST_CLEARED;
			res.stole  = 1'b0;
			case (r.op)
				OP_CLEAR: begin
					wipe();
					n_cleared++;
				end
				OP_STOP: begin
					// exact sub-channel code, inactive voices match too
					res.status = ST_NOT_FOUND;
					for (i = 0; i < VOICES; i++) begin
						if (v_entity[i] == r.ent && v_sub[i] == r.sub) begin
							v_end[i]    = '0;
							v_active[i] = 1'b0;
							res.idx     = 6'(i);
							res.status  = ST_STOPPED;
							break;
						end
					end
					if (res.status == ST_STOPPED) n_stopped++;
					else n_not_found++;
				end
				OP_START: begin
					pick = -1;
					best = LIFE_INIT;
					for (i = 0; i < VOICES; i++) begin
						// same entity and matching channel wins at once
						if (r.sub != SUB_NONE && v_entity[i] == r.ent &&
								(v_sub[i] == r.sub || r.sub == SUB_ANY)) begin
							pick = i;
							break;
						end
						// active player voices are protected from others
						if (v_active[i] && v_entity[i] == player && r.ent != player)
							continue;
						left = v_end[i] - {1'b0, r.now};
						if (left < best) begin
							best = left;
							pick = i;
						end
					end
					if (pick < 0) begin
						res.status = ST_NO_VOICE;
						n_no_voice++;
					end else begin
						res.idx        = 6'(pick);
						res.stole      = v_active[pick];
						v_active[pick] = 1'b0;
						v_sound[pick]  = '0;
						v_end[pick]    = '0;
						v_entity[pick] = r.ent;
						v_sub[pick]    = r.sub;
						if (r.aud) begin
							v_active[pick] = 1'b1;
							v_sound[pick]  = r.snd;
							v_end[pick]    = {1'b0, r.now} + {8'h00, r.len};
							res.status     = ST_STARTED;
							n_started++;
						end else begin
							res.status = ST_SILENT;
							n_silent++;
						end
						if (res.stole) n_stole++;
					end
				end
				default: return;
			endcase
			n_requests++;
			pending.push_back(res);
		endfunction

		function void check_result(voice_result_t got);
			voice_result_t want;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("error: result with nothing pending: index %0d status %0d stole %0b",
						got.idx, got.status, got.stole);
				return;
			end
			want = pending.pop_front();
			n_checked++;
			if (got.idx !== want.idx || got.status !== want.status || got.stole !== want.stole) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("error: result %0d expected index %0d status %0d stole %0b, got index %0d status %0d stole %0b",
						n_checked, want.idx, want.status, want.stole,
						got.idx, got.status, got.stole);
			end
		endfunction
	endclass

	logic                  clk           = 1'b0;
	logic                  arst_n        = 1'b0;
	logic [S_DATA_W-1:0]   s_axis_tdata  = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [M_DATA_W-1:0]   m_axis_tdata;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic                  cfg_we        = 1'b0;
	logic [15:0]           cfg_wdata     = '0;

	voice_scoreboard sb;
	int          src_idle_pct   = 0;
	int          sink_stall_pct = 0;
	int          quiet_cycles   = 0;
	logic [30:0] paint_time     = '0;

	sound_voice_allocator_core #(
		.VOICES(VOICES)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// transfer monitors, receiver stalls and the watchdog
	always @(posedge clk) begin
		voice_req_t    req;
		voice_result_t res;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				req.op  = s_axis_tdata[1:0];
				req.ent = s_axis_tdata[17:2];
				req.sub = s_axis_tdata[21:18];
				req.snd = s_axis_tdata[30:22];
				req.len = s_axis_tdata[54:31];
				req.now = s_axis_tdata[85:55];
				req.aud = s_axis_tdata[86];
				sb.note_request(req);
			end
			if (m_axis_tvalid && m_axis_tready) begin
				res.idx    = m_axis_tdata[5:0];
				res.status = status_t'(m_axis_tdata[8:6]);
				res.stole  = m_axis_tdata[9];
				sb.check_result(res);
			end
		end
		m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("error: no transfer for %0d cycles, %0d results pending",
				WATCHDOG_LIMIT, sb.pending.size());
			$display("simulation failed");
			$finish;
		end
	end

	function automatic voice_req_t make_req(logic [1:0] op, logic [15:0] ent, logic [3:0] sub,
			logic [8:0] snd, logic [23:0] len, logic [30:0] now, logic aud);
		voice_req_t r;
		r.op  = op;
		r.ent = ent;
		r.sub = sub;
		r.snd = snd;
		r.len = len;
		r.now = now;
		r.aud = aud;
		return r;
	endfunction

	// mostly starts and stops over a few entities so voices collide and get reused
	function automatic voice_req_t random_request();
		voice_req_t r;
		int roll, code;
		roll = $urandom_range(0, 99);
		if (roll < 64) r.op = OP_START;
		else if (roll < 94) r.op = OP_STOP;
		else if (roll < 97) r.op = OP_CLEAR;
		else r.op = OP_UNUSED;
		roll = $urandom_range(0, 99);
		if (roll < 20) r.ent = sb.player;
		else if (roll < 85) r.ent = ENTITY_POOL[$urandom_range(0, 3)];
		else r.ent = 16'($urandom);
		code  = $urandom_range(0, 8);
		r.sub = (code == 8) ? SUB_ANY : 4'(code);
		r.snd = 9'($urandom);
		roll  = $urandom_range(0, 99);
		if (roll < 85) r.len = 24'($urandom_range(0, 4000));
		else if (roll < 95) r.len = 24'($urandom);
		else r.len = (roll[0]) ? 24'hFFFFFF : 24'h000000;
		// painted time mostly creeps forward, now and then it jumps anywhere
		if ($urandom_range(0, 99) < 3) paint_time = 31'($urandom);
		else paint_time = paint_time + 31'($urandom_range(0, 1500));
		r.now = paint_time;
		r.aud = ($urandom_range(0, 99) < 85);
		return r;
	endfunction

	// valid stays up across back-to-back transfers
	task automatic send_request(input voice_req_t r);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tdata  <= {1'b0, r.aud, r.now, r.len, r.snd, r.sub, r.ent, r.op};
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// an unused opcode gives no result, so let the core settle after the last one
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_player(input logic [15:0] value);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		sb.player = value;
	endtask

	initial begin
		int k, p, sent;
		logic [15:0] setting;
		sb = new();
		sb.wipe();
		sb.player = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: player 0x1234 fills every voice, all ending at the life limit
		write_player(16'h1234);
		send_request(make_req(OP_CLEAR, 16'h0000, SUB_NONE, '0, '0, '0, 1'b0));
		for (k = 0; k < VOICES; k++)
			send_request(make_req(OP_START, 16'h1234, (k == VOICES - 1) ? SUB_NONE : 4'(k + 1),
				9'h1FF, 24'hFFFFFF, 31'h7F000000, 1'b1));
		// other entity finds only protected voices
		send_request(make_req(OP_START, 16'h0001, SUB_NONE, 9'h001, 24'd100, 31'd5, 1'b1));
		// remaining life equals the limit everywhere
		send_request(make_req(OP_START, 16'h1234, SUB_NONE, 9'h002, 24'd100, 31'd0, 1'b1));
		// stop, stop again on the now inactive voice, stop with no match
		send_request(make_req(OP_STOP, 16'h1234, 4'd3, '0, '0, '0, 1'b0));
		send_request(make_req(OP_STOP, 16'h1234, 4'd3, '0, '0, '0, 1'b0));
		send_request(make_req(OP_STOP, 16'hFFFF, SUB_ANY, '0, '0, '0, 1'b0));
		// silent claim of the freed voice, wildcard steal, exact hit
		send_request(make_req(OP_START, 16'h0001, 4'd2, 9'h0AA, 24'd50, 31'd0, 1'b0));
		send_request(make_req(OP_START, 16'h1234, SUB_ANY, 9'h000, 24'd0, 31'h7FFFFFFF, 1'b1));
		send_request(make_req(OP_START, 16'h0001, 4'd2, 9'h155, 24'd10, 31'd20, 1'b1));
		send_request(make_req(OP_UNUSED, 16'hFFFF, SUB_ANY, 9'h1FF, 24'hFFFFFF, 31'h7FFFFFFF, 1'b1));
		send_request(make_req(OP_CLEAR, 16'hFFFF, SUB_ANY, 9'h1FF, 24'hFFFFFF, 31'h7FFFFFFF, 1'b1));
		send_request(make_req(OP_START, 16'hFFFF, 4'd7, 9'h1FF, 24'hFFFFFF, 31'h7FFFFFFF, 1'b1));
		send_request(make_req(OP_START, 16'h0000, SUB_NONE, 9'h000, 24'd0, 31'd0, 1'b1));

		// random phases: new player entity and new idling pattern each time
		for (p = 0; p < PHASES; p++) begin
			wait_idle();
			setting = (p == 5 || p == 7) ? 16'($urandom) : PLAYER_SETTINGS[p];
			write_player(setting);
			case (p % 4)
				0: begin
					src_idle_pct   = 0;
					sink_stall_pct = 0;
				end
				1: begin
					src_idle_pct   = 58;
					sink_stall_pct = 0;
				end
				2: begin
					src_idle_pct   = 0;
					sink_stall_pct = 58;
				end
				default: begin
					src_idle_pct   = 24;
					sink_stall_pct = 24;
				end
			endcase
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				random_request_send: begin
					voice_req_t r;
					r = random_request();
					send_request(r);
					if (r.op != OP_UNUSED) sent++;
				end
			end
		end

		wait_idle();
		$display("covered %0d requests over %0d player settings: %0d started, %0d silent claims, %0d with no voice, %0d stealing an active voice",
			sb.n_requests, PHASES + 1, sb.n_started, sb.n_silent, sb.n_no_voice, sb.n_stole);
		$display("stops %0d hit and %0d missed, %0d clears, %0d results checked, %0d mismatches",
			sb.n_stopped, sb.n_not_found, sb.n_cleared, sb.n_checked, sb.mismatches);
		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

[sound_voice_allocator_core.f]
hdl/sva_pkg.sv
hdl/sva_cell.sv
hdl/sound_voice_allocator_core.sv
tb/tb_top.sv
